// File: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TCW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tcw check failed");

// checked on every edge, reset included
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tcw check failed");

`endif

// File: design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int CELL_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [1:0] OP_CURSOR = 2'd0;
  localparam logic [1:0] OP_PLACE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam logic [7:0] CHAR_BLANK = 8'd0;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_NOP,
    CMD_PLACE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        ch;
    logic [CELL_W-1:0] addr;
    logic              hit;
  } cmd_t;

endpackage
`default_nettype wire

// File: design/tcw_front.sv
`default_nettype none
module tcw_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic [1:0]                   operation,
  input  wire logic [7:0]                   char_code,
  input  wire logic [tcw_pkg::COL_W-1:0]    target_column,
  input  wire logic [tcw_pkg::ROW_W-1:0]    target_row,
  input  wire logic                         init_busy,
  output      logic                         cmd_valid,
  output      tcw_pkg::cmd_t                cmd,
  input  wire logic                         cmd_take
);

  tcw_pkg::cmd_t            cmd_in;
  logic [tcw_pkg::CELL_W:0] idx_wide;
  tcw_pkg::cmd_t            q [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               count;
  logic                     do_push;
  logic                     do_pop;

  assign idx_wide = (tcw_pkg::CELL_W+1)'(target_row) * (tcw_pkg::CELL_W+1)'(tcw_pkg::COLUMNS)
                  + (tcw_pkg::CELL_W+1)'(target_column);

  always_comb begin
    cmd_in.ch   = char_code;
    cmd_in.addr = idx_wide[tcw_pkg::CELL_W-1:0];
    cmd_in.hit  = (target_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                  (target_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS));
    case (operation)
      tcw_pkg::OP_CURSOR: begin
        if (char_code >= tcw_pkg::PRINT_LO && char_code <= tcw_pkg::PRINT_HI) begin
          cmd_in.kind = tcw_pkg::CMD_PRINT;
        end else if (char_code == tcw_pkg::CHAR_NL) begin
          cmd_in.kind = tcw_pkg::CMD_NEWLINE;
        end else if (char_code == tcw_pkg::CHAR_BS) begin
          cmd_in.kind = tcw_pkg::CMD_BACKSPACE;
        end else begin
          cmd_in.kind = tcw_pkg::CMD_NOP;
        end
      end
      tcw_pkg::OP_PLACE: cmd_in.kind = tcw_pkg::CMD_PLACE;
      tcw_pkg::OP_CLEAR: cmd_in.kind = tcw_pkg::CMD_CLEAR;
      default:           cmd_in.kind = tcw_pkg::CMD_READ;
    endcase
  end

  // held full while the store is being cleared after reset
  assign full      = (count == 2'd2) || init_busy;
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: design/tcw_back.sv
`default_nettype none
module tcw_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [7:0]                   cfg_data,
  input  wire logic                         cmd_valid,
  input  wire tcw_pkg::cmd_t                cmd,
  output      logic                         cmd_take,
  output      logic                         init_busy,
  output      logic                         empty,
  input  wire logic                         pop,
  output      logic [tcw_pkg::CELL_W-1:0]   cursor_cell,
  output      logic [tcw_pkg::COL_W-1:0]    cursor_column,
  output      logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output      logic [7:0]                   read_char,
  output      logic [7:0]                   read_attribute
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

  localparam logic [tcw_pkg::CELL_W-1:0] LAST_CELL  = tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::CELL_W-1:0] ROW_CELLS  = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::CELL_W-1:0] LAST_START =
    tcw_pkg::CELL_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL   = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  state_t                    state;
  logic [7:0]                colour;
  logic [tcw_pkg::CELL_W-1:0] cur_cell;
  logic [tcw_pkg::COL_W-1:0] cur_col;
  logic [tcw_pkg::ROW_W-1:0] cur_row;
  logic [tcw_pkg::CELL_W-1:0] scan;
  logic                      mv_valid;
  logic [tcw_pkg::CELL_W-1:0] mv_addr;
  logic                      rd_hit;
  logic                      out_valid;

  logic [15:0]               mem [tcw_pkg::CELLS];
  logic [15:0]               rdata;
  logic                      mem_we;
  logic [tcw_pkg::CELL_W-1:0] mem_waddr;
  logic [15:0]               mem_wdata;
  logic                      mem_re;
  logic [tcw_pkg::CELL_W-1:0] mem_raddr;

  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign init_busy = (state == S_INIT);
  assign empty     = !out_valid;

  // write port: a pending scroll move wins over blanking
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan;
    mem_wdata = {tcw_pkg::CHAR_BLANK, colour};
    mem_re    = 1'b0;
    mem_raddr = scan;
    if (mv_valid) begin
      mem_we    = 1'b1;
      mem_waddr = mv_addr;
      mem_wdata = rdata;
    end else begin
      case (state)
        S_INIT: begin
          mem_we    = 1'b1;
          mem_wdata = {tcw_pkg::CHAR_BLANK, tcw_pkg::ATTR_RESET};
        end
        S_CLEAR, S_BLANK: mem_we = 1'b1;
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              tcw_pkg::CMD_PRINT: begin
                mem_we    = 1'b1;
                mem_waddr = cur_cell;
                mem_wdata = {cmd.ch, colour};
              end
              tcw_pkg::CMD_BACKSPACE: begin
                mem_we    = (cur_cell != '0);
                mem_waddr = cur_cell - 1'b1;
              end
              tcw_pkg::CMD_PLACE: begin
                mem_we    = cmd.hit;
                mem_waddr = cmd.addr;
                mem_wdata = {cmd.ch, colour};
              end
              default: mem_we = 1'b0;
            endcase
          end
        end
        default: mem_we = 1'b0;
      endcase
    end
    if (state == S_SCROLL) begin
      mem_re = 1'b1;
    end else if (state == S_IDLE && cmd_valid && cmd.kind == tcw_pkg::CMD_READ) begin
      mem_re    = cmd.hit;
      mem_raddr = cmd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      colour    <= tcw_pkg::ATTR_RESET;
      cur_cell  <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      scan      <= '0;
      mv_valid  <= 1'b0;
      rd_hit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        colour <= cfg_data;
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      mv_valid <= 1'b0;
      case (state)
        S_INIT: begin
          if (scan == LAST_CELL) begin
            scan  <= '0;
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            rd_hit <= 1'b0;
            state  <= S_DONE;
            case (cmd.kind)
              tcw_pkg::CMD_PRINT, tcw_pkg::CMD_NEWLINE: begin
                if (cmd.kind == tcw_pkg::CMD_PRINT && cur_col != LAST_COL) begin
                  cur_col  <= cur_col + 1'b1;
                  cur_cell <= cur_cell + 1'b1;
                end else if (cur_row == LAST_ROW) begin
                  // ran off the bottom: scroll and park at the bottom row
                  cur_col  <= '0;
                  cur_cell <= LAST_START;
                  scan     <= ROW_CELLS;
                  state    <= S_SCROLL;
                end else begin
                  cur_col  <= '0;
                  cur_row  <= cur_row + 1'b1;
                  cur_cell <= cur_cell - tcw_pkg::CELL_W'(cur_col) + ROW_CELLS;
                end
              end
              tcw_pkg::CMD_BACKSPACE: begin
                if (cur_cell != '0) begin
                  cur_cell <= cur_cell - 1'b1;
                  if (cur_col == '0) begin
                    cur_col <= LAST_COL;
                    cur_row <= cur_row - 1'b1;
                  end else begin
                    cur_col <= cur_col - 1'b1;
                  end
                end
              end
              tcw_pkg::CMD_CLEAR: begin
                cur_cell <= '0;
                cur_col  <= '0;
                cur_row  <= '0;
                scan     <= '0;
                state    <= S_CLEAR;
              end
              tcw_pkg::CMD_READ: rd_hit <= cmd.hit;
              default: rd_hit <= 1'b0;
            endcase
          end
        end
        S_SCROLL: begin
          // read one row down, write it back one row up next cycle
          mv_valid <= 1'b1;
          mv_addr  <= scan - ROW_CELLS;
          if (scan == LAST_CELL) begin
            scan  <= LAST_START;
            state <= S_BLANK;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_BLANK: begin
          if (!mv_valid) begin
            if (scan == LAST_CELL) begin
              state <= S_DONE;
            end else begin
              scan <= scan + 1'b1;
            end
          end
        end
        S_CLEAR: begin
          if (scan == LAST_CELL) begin
            state <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            out_valid      <= 1'b1;
            cursor_cell    <= cur_cell;
            cursor_column  <= cur_col;
            cursor_row     <= cur_row;
            read_char      <= rd_hit ? rdata[15:8] : 8'd0;
            read_attribute <= rd_hit ? rdata[7:0] : 8'd0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/text_console_writer.sv
// channel   | direction | handshake               | payload
// input     | in        | push / full             | operation, char_code, target_column, target_row
// result    | out       | empty / pop             | cursor_cell, cursor_column, cursor_row,
//           |           |                         | read_char, read_attribute
// config    | in        | cfg_write (no wait)     | cfg_data (colour attribute)
//
// a plain request is executed in the back end, then its result is loaded into the result register once
// no earlier result waits or it is popped; a read follows the same steps, the store's registered read port
// returning data before the result is loaded. clear screen and a scroll make one store write per cycle.
// after rst the store is blanked, all CELLS (2000) cells, with full held high meanwhile.
// a two-entry request queue keeps input flowing while the back end works or a result waits.
`default_nettype none
module text_console_writer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic [1:0]                   operation,
  input  wire logic [7:0]                   char_code,
  input  wire logic [tcw_pkg::COL_W-1:0]    target_column,
  input  wire logic [tcw_pkg::ROW_W-1:0]    target_row,
  output      logic                         empty,
  input  wire logic                         pop,
  output      logic [tcw_pkg::CELL_W-1:0]   cursor_cell,
  output      logic [tcw_pkg::COL_W-1:0]    cursor_column,
  output      logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output      logic [7:0]                   read_char,
  output      logic [7:0]                   read_attribute,
  input  wire logic                         cfg_write,
  input  wire logic [7:0]                   cfg_data
);

  logic          cmd_valid;
  logic          cmd_take;
  logic          init_busy;
  tcw_pkg::cmd_t cmd;

  tcw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .char_code     (char_code),
    .target_column (target_column),
    .target_row    (target_row),
    .init_busy     (init_busy),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .init_busy      (init_busy),
    .empty          (empty),
    .pop            (pop),
    .cursor_cell    (cursor_cell),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .read_char      (read_char),
    .read_attribute (read_attribute)
  );

endmodule
`default_nettype wire

// File: design/tcw_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tcw_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         full,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [tcw_pkg::CELL_W-1:0]   cursor_cell,
  input wire logic [tcw_pkg::COL_W-1:0]    cursor_column,
  input wire logic [tcw_pkg::ROW_W-1:0]    cursor_row
);

  // reset empties the result side and starts the blanking pass
  `TCW_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (empty && full))

  // cursor stays on the screen
  `TCW_ASSERT(a_cursor_range, clk, rst, !empty |-> (cursor_column < tcw_pkg::COLUMNS && cursor_row < tcw_pkg::ROWS))

  // cell index agrees with column and row
  `TCW_ASSERT(a_cursor_cell, clk, rst, !empty |-> (cursor_cell == cursor_row * tcw_pkg::COLUMNS + cursor_column))

  // a waiting result is held until taken
  `TCW_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(cursor_cell)))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .cursor_cell   (cursor_cell),
  .cursor_column (cursor_column),
  .cursor_row    (cursor_row)
);
`default_nettype wire

// File: tb/tb_text_console_writer.sv
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 130;
  localparam int PHASE_ITEMS    = 72;
  localparam int COL_MAX        = 2**COL_W - 1;
  localparam int ROW_MAX        = 2**ROW_W - 1;

  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [7:0]        ch;
    logic [7:0]        attr;
  } cursor_report_t;

  // mirror of the screen store and cursor, one expected report per request
  class console_mirror;
    logic [7:0]     screen_char [CELLS];
    logic [7:0]     screen_attr [CELLS];
    int unsigned    cursor;
    logic [7:0]     colour;
    cursor_report_t awaited_reports[$];
    int             failures;

    function new();
      foreach (screen_char[i]) begin
        screen_char[i] = CHAR_BLANK;
        screen_attr[i] = ATTR_RESET;
      end
      cursor   = 0;
      colour   = ATTR_RESET;
      failures = 0;
    endfunction

    function void blank(int unsigned idx);
      screen_char[idx] = CHAR_BLANK;
      screen_attr[idx] = colour;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] ch,
                               logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      int unsigned    idx;
      bit             hit;
      cursor_report_t view;
      idx  = row * COLUMNS + col;
      hit  = (col < COLUMNS) && (row < ROWS);
      view = '0;
      case (op)
        OP_CURSOR: begin
          if (ch >= PRINT_LO && ch <= PRINT_HI) begin
            screen_char[cursor] = ch;
            screen_attr[cursor] = colour;
            cursor++;
          end else if (ch == CHAR_NL) begin
            cursor = (cursor / COLUMNS + 1) * COLUMNS;
          end else if (ch == CHAR_BS && cursor > 0) begin
            cursor--;
            blank(cursor);
          end
          // ran off the bottom: scroll up one row, blank the last row
          if (cursor >= CELLS) begin
            for (int i = COLUMNS; i < CELLS; i++) begin
              screen_char[i - COLUMNS] = screen_char[i];
              screen_attr[i - COLUMNS] = screen_attr[i];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) blank(i);
            cursor = CELLS - COLUMNS;
          end
        end
        OP_PLACE: begin
          if (hit) begin
            screen_char[idx] = ch;
            screen_attr[idx] = colour;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < CELLS; i++) blank(i);
          cursor = 0;
        end
        default: begin
          if (hit) begin
            view.ch   = screen_char[idx];
            view.attr = screen_attr[idx];
          end
        end
      endcase
      view.cell_idx = CELL_W'(cursor);
      view.column   = COL_W'(cursor % COLUMNS);
      view.row      = ROW_W'(cursor / COLUMNS);
      awaited_reports.push_back(view);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(cursor_report_t got);
      cursor_report_t want;
      if (awaited_reports.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none got cell %0d", $time, got.cell_idx);
        return;
      end
      want = awaited_reports.pop_front();
      compare("cursor_cell", want.cell_idx, got.cell_idx);
      compare("cursor_column", want.column, got.column);
      compare("cursor_row", want.row, got.row);
      compare("read_char", want.ch, got.ch);
      compare("read_attribute", want.attr, got.attr);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        operation = OP_CURSOR;
  logic [7:0]        char_code = CHAR_BLANK;
  logic [COL_W-1:0]  target_column = '0;
  logic [ROW_W-1:0]  target_row = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CELL_W-1:0] cursor_cell;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [7:0]        read_char;
  logic [7:0]        read_attribute;
  logic              cfg_write = 1'b0;
  logic [7:0]        cfg_data = ATTR_RESET;

  console_mirror board = new();
  bit            source_eager = 1'b0;
  bit            sink_holding = 1'b0;
  int            items_sent = 0;
  int            stall_cycles = 0;

  text_console_writer dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .char_code      (char_code),
    .target_column  (target_column),
    .target_row     (target_row),
    .empty          (empty),
    .pop            (pop),
    .cursor_cell    (cursor_cell),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .read_char      (read_char),
    .read_attribute (read_attribute),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(bit eager);
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 45) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COL_W-1:0] pick_column();
    if ($urandom_range(0, 9) == 0) return COL_W'($urandom_range(COLUMNS, COL_MAX));
    return COL_W'($urandom_range(0, COLUMNS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    if ($urandom_range(0, 9) == 0) return ROW_W'($urandom_range(ROWS, ROW_MAX));
    return ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int gap;
    bit ignored;
    push          <= 1'b1;
    operation     <= op;
    char_code     <= ch;
    target_column <= col;
    target_row    <= row;
    do @(posedge clk); while (full);
    board.note_request(op, ch, col, row);
    ignored = (op == OP_CURSOR && !((ch >= PRINT_LO && ch <= PRINT_HI) ||
                                    ch == CHAR_NL || ch == CHAR_BS)) ||
              (op == OP_PLACE && !(col < COLUMNS && row < ROWS));
    if (!ignored) items_sent++;
    gap = sink_holding ? 0 : pick_gap(source_eager);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_request(OP_CURSOR, ch, COL_W'($urandom), ROW_W'($urandom));
  endtask

  // stop offering and let every outstanding request come back
  task automatic settle();
    push <= 1'b0;
    while (board.awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    board.colour = value;
    cfg_write <= 1'b0;
  endtask

  task automatic random_burst();
    int               kind;
    int               len;
    int               pick;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    source_eager = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(1, 60);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 86) send_char(8'($urandom_range(PRINT_LO, PRINT_HI)));
        else if (pick < 91) send_char(CHAR_NL);
        else if (pick < 96) send_char(CHAR_BS);
        else send_char(8'($urandom));
      end
    end else if (kind < 55) begin
      // long runs of newlines reach the bottom row and force scrolls
      len = ($urandom_range(0, 3) == 0) ? ROWS + 1 : $urandom_range(1, 5);
      repeat (len) send_char(CHAR_NL);
    end else if (kind < 63) begin
      len = $urandom_range(1, 12);
      repeat (len) send_char(CHAR_BS);
    end else if (kind < 78) begin
      col = pick_column();
      row = pick_row();
      send_request(OP_PLACE, 8'($urandom), col, row);
      send_request(OP_READ, 8'($urandom), col, row);
    end else if (kind < 90) begin
      len = $urandom_range(1, 4);
      repeat (len) send_request(OP_READ, 8'($urandom), pick_column(), pick_row());
    end else if (kind < 93) begin
      send_request(OP_CLEAR, 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len)
        send_request(2'($urandom), 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin : request_source
    logic [7:0] attr_plan [4];
    int         start_count;
    attr_plan = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset contents, out of range reads and places, edge characters, a clear
    send_request(OP_READ, 8'h00, COL_W'(0), ROW_W'(0));
    send_request(OP_READ, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    send_request(OP_READ, 8'h00, COL_W'(COL_MAX), ROW_W'(ROW_MAX));
    send_request(OP_READ, 8'h00, COL_W'(COLUMNS), ROW_W'(0));
    send_request(OP_READ, 8'h00, COL_W'(0), ROW_W'(ROWS));
    send_char(CHAR_BS);
    send_char(PRINT_LO);
    send_char(PRINT_HI);
    send_char(8'd0);
    send_char(8'd31);
    send_char(8'd127);
    send_char(8'd255);
    send_char(CHAR_BS);
    send_char(CHAR_NL);
    send_request(OP_PLACE, 8'hFF, COL_W'(0), ROW_W'(0));
    send_request(OP_PLACE, 8'h41, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    send_request(OP_PLACE, 8'h42, COL_W'(COL_MAX), ROW_W'(ROW_MAX));
    send_request(OP_PLACE, 8'h43, COL_W'(COLUMNS), ROW_W'(3));
    send_request(OP_PLACE, 8'h44, COL_W'(5), ROW_W'(ROWS));
    send_request(OP_READ, 8'h00, COL_W'(0), ROW_W'(0));
    send_request(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    send_request(OP_READ, 8'h00, COL_W'(1), ROW_W'(0));
    send_request(OP_CLEAR, 8'hFF, COL_W'(COL_MAX), ROW_W'(ROW_MAX));
    send_request(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));

    for (int p = 0; p < 6; p++) begin
      settle();
      write_attribute(p < 4 ? attr_plan[p] : 8'($urandom));
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) random_burst();
    end

    settle();
    repeat (20) @(posedge clk);
    if (board.failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_sink
    int calm_left;
    int gap;
    int taken;
    bit eager;
    bit held;
    calm_left = 0;
    taken     = 0;
    eager     = 1'b0;
    held      = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (calm_left == 0) begin
        calm_left = $urandom_range(8, 40);
        eager     = ($urandom_range(0, 3) == 0);
      end
      calm_left--;
      gap = pick_gap(eager);
      if (!held && taken >= HOLD_AT_RESULT) begin
        // long hold-off so the request queue backs up and full rises
        held         = 1'b1;
        sink_holding = 1'b1;
        gap          = HOLD_CYCLES;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sink_holding = 1'b0;
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      board.check_result(cursor_report_t'{cursor_cell, cursor_column, cursor_row,
                                          read_char, read_attribute});
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
